// ----- rtl/mm3_pkg.sv -----
// Shared types, constants and helper functions of the MurmurHash3 x64_128 engine.
// Used by every module under rtl; depends on nothing else.
package mm3_pkg;

  localparam logic [63:0] MIX_C1    = 64'h87c37b91114253d5;
  localparam logic [63:0] MIX_C2    = 64'h4cf5ad432745937f;
  localparam logic [63:0] LANE_ADD1 = 64'h0000000052dce729;
  localparam logic [63:0] LANE_ADD2 = 64'h0000000038495ab5;
  localparam logic [63:0] FMIX_M1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_M2   = 64'hc4ceb9fe1a85ec53;

  localparam logic [4:0] BYTES_FULL = 5'd16;
  localparam logic [4:0] BYTES_HALF = 5'd8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [4:0]  byte_count;
    logic        last;
  } block_t;

  typedef struct packed {
    logic [63:0] hash_low;
    logic [63:0] hash_high;
    logic [63:0] hash_folded;
  } hash_t;

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len_add;
    logic        mix_lo;
    logic        mix_hi;
    logic        full;
    logic        last;
    logic        start;
    logic [31:0] seed;
  } op_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_K1A,
    ST_K1B,
    ST_K2A,
    ST_K2B,
    ST_MIX1,
    ST_MIX2,
    ST_MIX3,
    ST_MIX4,
    ST_TAIL,
    ST_FXOR,
    ST_FADD1A,
    ST_FADD1B,
    ST_M1A,
    ST_M1B,
    ST_M2A,
    ST_M2B,
    ST_FADD2A,
    ST_FADD2B,
    ST_OUT
  } back_state_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int r);
    rotl64 = (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] fold33(input logic [63:0] v);
    fold33 = v ^ (v >> 33);
  endfunction

endpackage

// ----- rtl/murmur3_x64_128_hash.sv -----
// Top level of the MurmurHash3 x64_128 streaming engine: seed register and wiring.
// Depends on mm3_pkg, mm3_front, mm3_queue, mm3_mul and mm3_back.

// A message arrives as 16-byte blocks, little-endian, with last set on its final
// block; that block may carry 0 to 16 valid bytes, and only it produces a hash
// request (h1, h2 and h1 ^ h2). The front end takes a block whenever its two-entry
// queue has room, so a few blocks can be buffered while the back end works. The
// back end shares one iterative multiplier that forms a 64-bit product from three
// 32-bit partial products. A full block takes a pop, four multiplies and four
// lane steps; a short final block with n bytes takes a pop, two multiplies and a
// tail step when n is 1 to 8, or four multiplies and a tail step when n is 9 to
// 15; an empty final block takes only the pop; and finalization adds four
// multiplies, five add or xor steps and the output step before the result is
// offered. The seed is sampled when the first block of a message is accepted;
// write it through the seed port, which is always ready.
module murmur3_x64_128_hash (
  input  logic            clk,
  input  logic            rst,
  input  logic            block_valid,
  output logic            block_stall,
  input  mm3_pkg::block_t block,
  output logic            hash_valid,
  input  logic            hash_stall,
  output mm3_pkg::hash_t  hash,
  input  logic            seed_valid,
  output logic            seed_ready,
  input  logic [31:0]     seed_data
);

  logic              [31:0] seed;
  logic                     push;
  logic                     pop;
  logic                     queue_full;
  logic                     queue_empty;
  mm3_pkg::op_t             op_in;
  mm3_pkg::op_t             op_out;
  mm3_pkg::mul_req_t        mul_req;
  logic                     mul_done;
  logic              [63:0] mul_product;

  assign seed_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'h0;
    end else if (seed_valid && seed_ready) begin
      seed <= seed_data;
    end
  end

  mm3_front u_front (
    .clk         (clk),
    .rst         (rst),
    .block_valid (block_valid),
    .block_stall (block_stall),
    .block       (block),
    .seed        (seed),
    .queue_full  (queue_full),
    .push        (push),
    .op          (op_in)
  );

  mm3_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .op_in  (op_in),
    .full   (queue_full),
    .pop    (pop),
    .op_out (op_out),
    .empty  (queue_empty)
  );

  mm3_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_product)
  );

  mm3_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (queue_empty),
    .op          (op_out),
    .pop         (pop),
    .mul_req     (mul_req),
    .mul_done    (mul_done),
    .mul_product (mul_product),
    .hash_valid  (hash_valid),
    .hash_stall  (hash_stall),
    .hash        (hash)
  );

endmodule

// ----- rtl/mm3_front.sv -----
// Front end: accepts message blocks, masks unused bytes and classifies each request.
// Depends on mm3_pkg; feeds mm3_queue.
module mm3_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            block_valid,
  output logic            block_stall,
  input  mm3_pkg::block_t block,
  input  logic [31:0]     seed,
  input  logic            queue_full,
  output logic            push,
  output mm3_pkg::op_t    op
);

  logic       in_message;
  logic [4:0] count;

  assign block_stall = queue_full;
  assign push        = block_valid && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
    end else if (push) begin
      in_message <= !block.last;
    end
  end

  always_comb begin
    // Only the last block of a message may be short; counts above a full block saturate.
    if (!block.last || block.byte_count > mm3_pkg::BYTES_FULL) begin
      count = mm3_pkg::BYTES_FULL;
    end else begin
      count = block.byte_count;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      op.lo[8*i +: 8] = (5'(i) < count) ? block.block_low[8*i +: 8] : 8'h00;
      op.hi[8*i +: 8] = (5'(i + 8) < count) ? block.block_high[8*i +: 8] : 8'h00;
    end
    op.len_add = count;
    op.mix_lo  = count != 5'd0;
    op.mix_hi  = count > mm3_pkg::BYTES_HALF;
    op.full    = count == mm3_pkg::BYTES_FULL;
    op.last    = block.last;
    op.start   = !in_message;
    op.seed    = seed;
  end

endmodule

// ----- rtl/mm3_queue.sv -----
// Short request queue that decouples the front end from the mixing back end.
// Depends on mm3_pkg for the request type and depth.
module mm3_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  mm3_pkg::op_t op_in,
  output logic         full,
  input  logic         pop,
  output mm3_pkg::op_t op_out,
  output logic         empty
);

  mm3_pkg::op_t                      entries [mm3_pkg::QUEUE_DEPTH];
  logic [mm3_pkg::QUEUE_PTR_W-1:0]   wr_ptr;
  logic [mm3_pkg::QUEUE_PTR_W-1:0]   rd_ptr;
  logic [mm3_pkg::QUEUE_CNT_W-1:0]   fill;

  localparam logic [mm3_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
    mm3_pkg::QUEUE_PTR_W'(mm3_pkg::QUEUE_DEPTH - 1);
  localparam logic [mm3_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
    mm3_pkg::QUEUE_CNT_W'(mm3_pkg::QUEUE_DEPTH);

  assign full   = fill == DEPTH_CNT;
  assign empty  = fill == '0;
  assign op_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + mm3_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - mm3_pkg::QUEUE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= op_in;
    end
  end

endmodule

// ----- rtl/mm3_mul.sv -----
// Iterative 64 by 64 multiplier that keeps the low 64 bits of the product.
// One 32 by 32 partial product per cycle; depends on mm3_pkg for the request type.
module mm3_mul (
  input  logic              clk,
  input  logic              rst,
  input  mm3_pkg::mul_req_t req,
  output logic              done,
  output logic [63:0]       product
);

  logic        busy;
  logic [1:0]  phase;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [31:0] a_sel;
  logic [31:0] b_sel;
  logic [63:0] part;
  logic [63:0] acc;

  // Low by low first, then the two cross terms, of which only the low half matters.
  always_comb begin
    a_sel = (phase == 2'd2) ? a_r[63:32] : a_r[31:0];
    b_sel = (phase == 2'd1) ? b_r[63:32] : b_r[31:0];
  end

  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        phase <= 2'd0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (busy) begin
      part <= 64'(a_sel) * 64'(b_sel);
      case (phase)
        2'd1: begin
          acc <= part;
        end
        2'd2, 2'd3: begin
          acc <= acc + {part[31:0], 32'h0};
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

endmodule

// ----- rtl/mm3_back.sv -----
// Back end: sequencer that mixes queued requests into the two lanes and finalizes.
// Depends on mm3_pkg; drives the shared mm3_mul unit and the result register.
module mm3_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  mm3_pkg::op_t      op,
  output logic              pop,
  output mm3_pkg::mul_req_t mul_req,
  input  logic              mul_done,
  input  logic [63:0]       mul_product,
  output logic              hash_valid,
  input  logic              hash_stall,
  output mm3_pkg::hash_t    hash
);

  mm3_pkg::back_state_t state;
  mm3_pkg::back_state_t state_next;
  mm3_pkg::op_t         cur;
  logic                 mul_wait;
  logic [63:0]          lane_one;
  logic [63:0]          lane_two;
  logic [63:0]          msg_len;
  logic [63:0]          k1;
  logic [63:0]          k2;
  logic                 out_free;
  logic                 mul_state;

  assign out_free = !hash_valid || !hash_stall;

  always_comb begin
    state_next = state;
    case (state)
      mm3_pkg::ST_IDLE: begin
        if (!empty) begin
          if (op.mix_lo) begin
            state_next = mm3_pkg::ST_K1A;
          end else begin
            state_next = mm3_pkg::ST_FXOR;
          end
        end
      end
      mm3_pkg::ST_K1A: begin
        if (mul_done) state_next = mm3_pkg::ST_K1B;
      end
      mm3_pkg::ST_K1B: begin
        if (mul_done) begin
          if (cur.mix_hi) begin
            state_next = mm3_pkg::ST_K2A;
          end else begin
            state_next = mm3_pkg::ST_TAIL;
          end
        end
      end
      mm3_pkg::ST_K2A: begin
        if (mul_done) state_next = mm3_pkg::ST_K2B;
      end
      mm3_pkg::ST_K2B: begin
        if (mul_done) begin
          state_next = cur.full ? mm3_pkg::ST_MIX1 : mm3_pkg::ST_TAIL;
        end
      end
      mm3_pkg::ST_MIX1:   state_next = mm3_pkg::ST_MIX2;
      mm3_pkg::ST_MIX2:   state_next = mm3_pkg::ST_MIX3;
      mm3_pkg::ST_MIX3:   state_next = mm3_pkg::ST_MIX4;
      mm3_pkg::ST_MIX4: begin
        state_next = cur.last ? mm3_pkg::ST_FXOR : mm3_pkg::ST_IDLE;
      end
      mm3_pkg::ST_TAIL:   state_next = mm3_pkg::ST_FXOR;
      mm3_pkg::ST_FXOR:   state_next = mm3_pkg::ST_FADD1A;
      mm3_pkg::ST_FADD1A: state_next = mm3_pkg::ST_FADD1B;
      mm3_pkg::ST_FADD1B: state_next = mm3_pkg::ST_M1A;
      mm3_pkg::ST_M1A: begin
        if (mul_done) state_next = mm3_pkg::ST_M1B;
      end
      mm3_pkg::ST_M1B: begin
        if (mul_done) state_next = mm3_pkg::ST_M2A;
      end
      mm3_pkg::ST_M2A: begin
        if (mul_done) state_next = mm3_pkg::ST_M2B;
      end
      mm3_pkg::ST_M2B: begin
        if (mul_done) state_next = mm3_pkg::ST_FADD2A;
      end
      mm3_pkg::ST_FADD2A: state_next = mm3_pkg::ST_FADD2B;
      mm3_pkg::ST_FADD2B: state_next = mm3_pkg::ST_OUT;
      mm3_pkg::ST_OUT: begin
        if (out_free) state_next = mm3_pkg::ST_IDLE;
      end
      default: state_next = mm3_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == mm3_pkg::ST_IDLE) && !empty;
    mul_state = 1'b1;
    mul_req.a = k1;
    mul_req.b = mm3_pkg::MIX_C2;
    case (state)
      mm3_pkg::ST_K1A: begin
        mul_req.a = cur.lo;
        mul_req.b = mm3_pkg::MIX_C1;
      end
      mm3_pkg::ST_K1B: begin
        mul_req.a = k1;
        mul_req.b = mm3_pkg::MIX_C2;
      end
      mm3_pkg::ST_K2A: begin
        mul_req.a = cur.hi;
        mul_req.b = mm3_pkg::MIX_C2;
      end
      mm3_pkg::ST_K2B: begin
        mul_req.a = k2;
        mul_req.b = mm3_pkg::MIX_C1;
      end
      mm3_pkg::ST_M1A: begin
        mul_req.a = mm3_pkg::fold33(lane_one);
        mul_req.b = mm3_pkg::FMIX_M1;
      end
      mm3_pkg::ST_M1B: begin
        mul_req.a = k1;
        mul_req.b = mm3_pkg::FMIX_M2;
      end
      mm3_pkg::ST_M2A: begin
        mul_req.a = mm3_pkg::fold33(lane_two);
        mul_req.b = mm3_pkg::FMIX_M1;
      end
      mm3_pkg::ST_M2B: begin
        mul_req.a = k2;
        mul_req.b = mm3_pkg::FMIX_M2;
      end
      default: begin
        mul_state = 1'b0;
      end
    endcase
    // Each multiply state issues once and then waits for the unit to finish.
    mul_req.start = mul_state && !mul_wait;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mm3_pkg::ST_IDLE;
      mul_wait   <= 1'b0;
      hash_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_req.start) begin
        mul_wait <= 1'b1;
      end else if (mul_done) begin
        mul_wait <= 1'b0;
      end
      if (state == mm3_pkg::ST_OUT && out_free) begin
        hash_valid <= 1'b1;
      end else if (!hash_stall) begin
        hash_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mm3_pkg::ST_IDLE: begin
        if (!empty) begin
          cur <= op;
          if (op.start) begin
            lane_one <= {32'h0, op.seed};
            lane_two <= {32'h0, op.seed};
            msg_len  <= 64'(op.len_add);
          end else begin
            msg_len <= msg_len + 64'(op.len_add);
          end
        end
      end
      mm3_pkg::ST_K1A: begin
        if (mul_done) k1 <= mm3_pkg::rotl64(mul_product, 31);
      end
      mm3_pkg::ST_K1B: begin
        if (mul_done) k1 <= mul_product;
      end
      mm3_pkg::ST_K2A: begin
        if (mul_done) k2 <= mm3_pkg::rotl64(mul_product, 33);
      end
      mm3_pkg::ST_K2B: begin
        if (mul_done) k2 <= mul_product;
      end
      mm3_pkg::ST_MIX1: begin
        lane_one <= mm3_pkg::rotl64(lane_one ^ k1, 27) + lane_two;
      end
      mm3_pkg::ST_MIX2: begin
        lane_one <= {lane_one[61:0], 2'b00} + lane_one + mm3_pkg::LANE_ADD1;
      end
      mm3_pkg::ST_MIX3: begin
        lane_two <= mm3_pkg::rotl64(lane_two ^ k2, 31) + lane_one;
      end
      mm3_pkg::ST_MIX4: begin
        lane_two <= {lane_two[61:0], 2'b00} + lane_two + mm3_pkg::LANE_ADD2;
      end
      mm3_pkg::ST_TAIL: begin
        if (cur.mix_lo) lane_one <= lane_one ^ k1;
        if (cur.mix_hi) lane_two <= lane_two ^ k2;
      end
      mm3_pkg::ST_FXOR: begin
        lane_one <= lane_one ^ msg_len;
        lane_two <= lane_two ^ msg_len;
      end
      mm3_pkg::ST_FADD1A, mm3_pkg::ST_FADD2A: begin
        lane_one <= lane_one + lane_two;
      end
      mm3_pkg::ST_FADD1B, mm3_pkg::ST_FADD2B: begin
        lane_two <= lane_two + lane_one;
      end
      mm3_pkg::ST_M1A: begin
        if (mul_done) k1 <= mm3_pkg::fold33(mul_product);
      end
      mm3_pkg::ST_M1B: begin
        if (mul_done) lane_one <= mm3_pkg::fold33(mul_product);
      end
      mm3_pkg::ST_M2A: begin
        if (mul_done) k2 <= mm3_pkg::fold33(mul_product);
      end
      mm3_pkg::ST_M2B: begin
        if (mul_done) lane_two <= mm3_pkg::fold33(mul_product);
      end
      mm3_pkg::ST_OUT: begin
        if (out_free) begin
          hash.hash_low    <= lane_one;
          hash.hash_high   <= lane_two;
          hash.hash_folded <= lane_one ^ lane_two;
        end
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for murmur3_x64_128_hash: streams messages of 16-byte blocks and checks each hash
// against a cycle-free model kept in a small scoreboard class. Depends on every file under rtl.
module tb_top;

  localparam int  CLK_HALF     = 5;
  localparam int  RESET_CYCLES = 5;
  localparam int  SETTLE_CYCLES = 300;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  RANDOM_ITEMS = 2000;
  localparam int  PHASE_ITEMS  = 250;
  localparam int  CYCLE_LIMIT  = 1000000;

  // Keeps the expected hashes in arrival order and the lane state that produces them.
  class hash_scoreboard;
    localparam logic [63:0] K_LOW   = 64'h87c37b91114253d5;
    localparam logic [63:0] K_HIGH  = 64'h4cf5ad432745937f;
    localparam logic [63:0] STEP_A  = 64'h0000000052dce729;
    localparam logic [63:0] STEP_B  = 64'h0000000038495ab5;
    localparam logic [63:0] AVAL_M1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] AVAL_M2 = 64'hc4ceb9fe1a85ec53;

    logic [31:0]    seed_value;
    logic [63:0]    lane_a;
    logic [63:0]    lane_b;
    logic [63:0]    byte_total;
    bit             open_msg;
    mm3_pkg::hash_t expected_hashes[$];
    int             errors;
    int             hashes_checked;
    int             blocks_seen;
    int             messages_seen;

    function new();
      seed_value = '0;
      lane_a = '0;
      lane_b = '0;
      byte_total = '0;
      open_msg = 1'b0;
      errors = 0;
      hashes_checked = 0;
      blocks_seen = 0;
      messages_seen = 0;
    endfunction

    function logic [63:0] rot_left(input logic [63:0] v, input int r);
      return (v << r) | (v >> (64 - r));
    endfunction

    function logic [63:0] key_mix_low(input logic [63:0] k);
      logic [63:0] t;
      t = k * K_LOW;
      t = rot_left(t, 31);
      return t * K_HIGH;
    endfunction

    function logic [63:0] key_mix_high(input logic [63:0] k);
      logic [63:0] t;
      t = k * K_HIGH;
      t = rot_left(t, 33);
      return t * K_LOW;
    endfunction

    function logic [63:0] avalanche(input logic [63:0] h);
      logic [63:0] t;
      t = h ^ (h >> 33);
      t = t * AVAL_M1;
      t = t ^ (t >> 33);
      t = t * AVAL_M2;
      return t ^ (t >> 33);
    endfunction

    function logic [63:0] keep_bytes(input logic [63:0] v, input int n);
      if (n >= 8) return v;
      return v & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function void absorb(input logic [63:0] lo, input logic [63:0] hi);
      lane_a = lane_a ^ key_mix_low(lo);
      lane_a = rot_left(lane_a, 27);
      lane_a = lane_a + lane_b;
      lane_a = lane_a * 64'd5 + STEP_A;
      lane_b = lane_b ^ key_mix_high(hi);
      lane_b = rot_left(lane_b, 31);
      lane_b = lane_b + lane_a;
      lane_b = lane_b * 64'd5 + STEP_B;
    endfunction

    function void set_seed(input logic [31:0] v);
      seed_value = v;
    endfunction

    function int pending();
      return expected_hashes.size();
    endfunction

    function void note_block(input mm3_pkg::block_t b);
      int             n;
      logic [63:0]    h1;
      logic [63:0]    h2;
      mm3_pkg::hash_t h;
      blocks_seen++;
      if (!open_msg) begin
        lane_a = {32'd0, seed_value};
        lane_b = {32'd0, seed_value};
        byte_total = '0;
        open_msg = 1'b1;
      end
      if (!b.last) begin
        absorb(b.block_low, b.block_high);
        byte_total = byte_total + 64'd16;
        return;
      end
      n = (b.byte_count > mm3_pkg::BYTES_FULL) ? 16 : int'(b.byte_count);
      if (n == 16) begin
        absorb(b.block_low, b.block_high);
      end else begin
        if (n > 8) lane_b = lane_b ^ key_mix_high(keep_bytes(b.block_high, n - 8));
        if (n > 0) lane_a = lane_a ^ key_mix_low(keep_bytes(b.block_low, n));
      end
      byte_total = byte_total + 64'(n);
      h1 = lane_a ^ byte_total;
      h2 = lane_b ^ byte_total;
      h1 = h1 + h2;
      h2 = h2 + h1;
      h1 = avalanche(h1);
      h2 = avalanche(h2);
      h1 = h1 + h2;
      h2 = h2 + h1;
      lane_a = h1;
      lane_b = h2;
      open_msg = 1'b0;
      messages_seen++;
      h.hash_low = h1;
      h.hash_high = h2;
      h.hash_folded = h1 ^ h2;
      expected_hashes.push_back(h);
    endfunction

    function void check_hash(input mm3_pkg::hash_t got);
      mm3_pkg::hash_t want;
      if (expected_hashes.size() == 0) begin
        errors++;
        $display("%0t: hash with no message pending: %h %h %h", $time,
                 got.hash_low, got.hash_high, got.hash_folded);
        return;
      end
      want = expected_hashes.pop_front();
      hashes_checked++;
      if (got.hash_low !== want.hash_low) begin
        errors++;
        $display("%0t: hash_low expected %h actual %h", $time, want.hash_low, got.hash_low);
      end
      if (got.hash_high !== want.hash_high) begin
        errors++;
        $display("%0t: hash_high expected %h actual %h", $time, want.hash_high, got.hash_high);
      end
      if (got.hash_folded !== want.hash_folded) begin
        errors++;
        $display("%0t: hash_folded expected %h actual %h", $time,
                 want.hash_folded, got.hash_folded);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            block_valid = 1'b0;
  logic            block_stall;
  mm3_pkg::block_t block = '0;
  logic            hash_valid;
  logic            hash_stall = 1'b0;
  mm3_pkg::hash_t  hash;
  logic            seed_valid = 1'b0;
  logic            seed_ready;
  logic [31:0]     seed_data = '0;

  hash_scoreboard scoreboard = new();
  bit  gaps_on = 1'b1;
  bit  hold_request = 1'b0;
  int  items_sent = 0;
  int  seeds_written = 0;
  int  cycles = 0;

  murmur3_x64_128_hash uut (
    .clk        (clk),
    .rst        (rst),
    .block_valid(block_valid),
    .block_stall(block_stall),
    .block      (block),
    .hash_valid (hash_valid),
    .hash_stall (hash_stall),
    .hash       (hash),
    .seed_valid (seed_valid),
    .seed_ready (seed_ready),
    .seed_data  (seed_data)
  );

  always #CLK_HALF clk = ~clk;

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: check every accepted request, then pick the stall for the next edge, or hold it on when asked.
  initial begin : hash_sink
    forever begin
      @(posedge clk);
      if (!rst && hash_valid && !hash_stall) scoreboard.check_hash(hash);
      if (hold_request) begin
        hold_request = 1'b0;
        hash_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      hash_stall <= gaps_on && ($urandom_range(99) < 16);
    end
  end

  function automatic logic [63:0] pick_word();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic mm3_pkg::block_t make_block(input bit is_last, input logic [4:0] count);
    mm3_pkg::block_t b;
    b.block_low = pick_word();
    b.block_high = pick_word();
    b.byte_count = count;
    b.last = is_last;
    return b;
  endfunction

  function automatic mm3_pkg::block_t fixed_block(input logic [63:0] lo,
                                                  input logic [63:0] hi,
                                                  input logic [4:0] count, input bit is_last);
    mm3_pkg::block_t b;
    b.block_low = lo;
    b.block_high = hi;
    b.byte_count = count;
    b.last = is_last;
    return b;
  endfunction

  task automatic send_block(input mm3_pkg::block_t b);
    while (gaps_on && ($urandom_range(99) < 16)) begin
      block_valid <= 1'b0;
      @(posedge clk);
    end
    block_valid <= 1'b1;
    block <= b;
    @(posedge clk);
    while (block_stall) @(posedge clk);
    scoreboard.note_block(b);
    items_sent++;
  endtask

  // Non-last blocks carry a random byte count, which the block must ignore.
  task automatic send_message(input int blocks, input logic [4:0] last_count);
    for (int i = 0; i < blocks - 1; i++) send_block(make_block(1'b0, 5'($urandom_range(31))));
    send_block(make_block(1'b1, last_count));
  endtask

  task automatic write_seed(input logic [31:0] v);
    seed_valid <= 1'b1;
    seed_data <= v;
    @(posedge clk);
    while (!seed_ready) @(posedge clk);
    seed_valid <= 1'b0;
    scoreboard.set_seed(v);
    seeds_written++;
  endtask

  // Waits for every hash, then lets any non-final block finish inside the engine.
  task automatic settle();
    block_valid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [4:0] pick_last_count();
    if ($urandom_range(9) == 0) return 5'($urandom_range(31, 17));
    return 5'($urandom_range(16));
  endfunction

  function automatic int pick_length();
    if ($urandom_range(7) == 0) return $urandom_range(12, 5);
    return $urandom_range(4, 1);
  endfunction

  initial begin : stimulus
    int          phase;
    int          phase_start;
    int          random_start;
    logic [31:0] seed_pick;
    rst <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, first with the seed left at its reset value.
    send_block(fixed_block('1, '1, 5'd0, 1'b1));
    send_block(fixed_block('0, '0, 5'd16, 1'b1));
    send_block(fixed_block('1, '1, 5'd1, 1'b1));
    send_block(fixed_block('1, '1, 5'd7, 1'b1));
    send_block(fixed_block('1, '1, 5'd8, 1'b1));
    send_block(fixed_block('1, '1, 5'd9, 1'b1));
    send_block(fixed_block('1, '1, 5'd15, 1'b1));
    send_block(make_block(1'b1, 5'd17));
    send_block(make_block(1'b1, 5'd31));
    send_block(fixed_block('1, '0, 5'd0, 1'b0));
    send_block(fixed_block('0, '1, 5'd12, 1'b1));
    send_block(make_block(1'b0, 5'd31));
    send_block(make_block(1'b0, 5'd5));
    send_block(make_block(1'b1, 5'd16));
    // A seed written inside a message only applies to the next one.
    send_block(make_block(1'b0, 5'd16));
    settle();
    write_seed(32'hffffffff);
    send_block(make_block(1'b1, 5'd3));
    send_block(fixed_block('0, '0, 5'd0, 1'b1));
    send_block(fixed_block('1, '1, 5'd16, 1'b1));
    settle();

    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      case (phase % 6)
        0: seed_pick = 32'd0;
        1: seed_pick = 32'hffffffff;
        2: seed_pick = $urandom;
        3: seed_pick = 32'd1;
        4: seed_pick = 32'h80000000;
        default: seed_pick = $urandom;
      endcase
      write_seed(seed_pick);
      gaps_on = (phase != 2);
      phase_start = items_sent;
      if (phase == 4) begin
        // Hold the result side off while single-block messages keep coming.
        gaps_on = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 60; i++) send_message(1, pick_last_count());
        gaps_on = 1'b1;
      end
      while (items_sent - phase_start < PHASE_ITEMS) send_message(pick_length(), pick_last_count());
      settle();
      gaps_on = 1'b1;
      phase++;
    end

    $display("Sent %0d blocks in %0d messages under %0d seed settings; %0d hashes compared.",
             scoreboard.blocks_seen, scoreboard.messages_seen, seeds_written,
             scoreboard.hashes_checked);
    if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mm3_pkg.sv
rtl/mm3_front.sv
rtl/mm3_queue.sv
rtl/mm3_mul.sv
rtl/mm3_back.sv
rtl/murmur3_x64_128_hash.sv
dv/tb_top.sv
